/* rtl/bracket_text_pretty_printer_unit_macros.svh */
// Assertion macros shared by the pretty printer modules.
`ifndef BRACKET_TEXT_PRETTY_PRINTER_UNIT_MACROS_SVH
`define BRACKET_TEXT_PRETTY_PRINTER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BTPP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BTPP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/btpp_pkg.sv */
package btpp_pkg;

    localparam int MAX_DEPTH_DEF = 32;
    localparam int DEPTH_W       = 6;
    localparam int Q_DEPTH       = 2;

    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    localparam logic [1:0] OP_PASS  = 2'd0;
    localparam logic [1:0] OP_OPEN  = 2'd1;
    localparam logic [1:0] OP_CLOSE = 2'd2;
    localparam logic [1:0] OP_COLON = 2'd3;

    typedef struct packed {
        logic [7:0] in_char;
        logic       first_of_text;
    } t_in;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_of_run;
    } t_out;

    typedef struct packed {
        logic [1:0]         op;
        logic [7:0]         ch;
        logic [DEPTH_W-1:0] tabs;
    } t_cmd;

    typedef struct packed {
        logic push;
        t_cmd cmd;
    } t_q_wr;

    typedef struct packed {
        logic avail;
        t_cmd cmd;
    } t_q_rd;

endpackage

/* rtl/btpp_front.sv */
module btpp_front #(
    parameter int MAX_DEPTH = btpp_pkg::MAX_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  btpp_pkg::t_in   i_data,
    input  logic            i_q_full,
    output btpp_pkg::t_q_wr o_q_wr
);
    import btpp_pkg::*;
    `include "bracket_text_pretty_printer_unit_macros.svh"

    localparam logic [DEPTH_W-1:0] MaxD = DEPTH_W'(MAX_DEPTH);

    logic [DEPTH_W-1:0] r_depth, n_depth;
    logic               r_in_str, n_in_str;
    logic               r_esc, n_esc;
    logic [DEPTH_W-1:0] depth_cur;
    logic               in_str_cur;
    logic               esc_cur;
    logic               accept;
    t_cmd               cmd;

    assign o_stall = i_q_full;
    assign accept  = i_valid && !i_q_full;

    always_comb begin
        depth_cur  = i_data.first_of_text ? '0 : r_depth;
        in_str_cur = i_data.first_of_text ? 1'b0 : r_in_str;
        esc_cur    = i_data.first_of_text ? 1'b0 : r_esc;
        n_depth    = depth_cur;
        n_in_str   = in_str_cur;
        n_esc      = esc_cur;
        cmd.op     = OP_PASS;
        cmd.ch     = i_data.in_char;
        cmd.tabs   = depth_cur;
        if (in_str_cur) begin
            if (esc_cur) begin
                n_esc = 1'b0;
            end else if (i_data.in_char == CH_BSLASH) begin
                n_esc = 1'b1;
            end else if (i_data.in_char == CH_QUOTE) begin
                n_in_str = 1'b0;
            end
        end else begin
            case (i_data.in_char)
                CH_LBRACE, CH_LBRACK: begin
                    if (depth_cur < MaxD) begin
                        n_depth = depth_cur + 1'b1;
                    end
                    cmd.op   = OP_OPEN;
                    cmd.tabs = n_depth;
                end
                CH_RBRACE, CH_RBRACK: begin
                    if (depth_cur != '0) begin
                        n_depth = depth_cur - 1'b1;
                    end
                    cmd.op   = OP_CLOSE;
                    cmd.tabs = n_depth;
                end
                CH_COLON: begin
                    cmd.op = OP_COLON;
                end
                CH_COMMA: begin
                    cmd.op = OP_OPEN;
                end
                CH_QUOTE: begin
                    n_in_str = 1'b1;
                end
                default: begin
                    cmd.op = OP_PASS;
                end
            endcase
        end
    end

    assign o_q_wr.push = accept;
    assign o_q_wr.cmd  = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth  <= '0;
            r_in_str <= 1'b0;
            r_esc    <= 1'b0;
        end else if (accept) begin
            r_depth  <= n_depth;
            r_in_str <= n_in_str;
            r_esc    <= n_esc;
        end
    end

    `BTPP_ASSERT_SAME(a_depth_limit, i_clk, i_rst_n, 1'b1, r_depth <= MaxD, "depth above limit")

endmodule

/* rtl/btpp_queue.sv */
module btpp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  btpp_pkg::t_q_wr i_wr,
    output logic            o_full,
    output btpp_pkg::t_q_rd o_rd,
    input  logic            i_pop
);
    import btpp_pkg::*;
    `include "bracket_text_pretty_printer_unit_macros.svh"

    localparam int PtrW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CntW = $clog2(Q_DEPTH + 1);

    t_cmd            r_mem [Q_DEPTH];
    logic [PtrW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0] r_count, n_count;
    logic            do_push;
    logic            do_pop;

    assign o_full    = (r_count == CntW'(Q_DEPTH));
    assign o_rd.avail = (r_count != '0);
    assign o_rd.cmd   = r_mem[r_rd_ptr];
    assign do_push   = i_wr.push && !o_full;
    assign do_pop    = i_pop && o_rd.avail;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PtrW'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PtrW'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wr.cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    `BTPP_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CntW'(Q_DEPTH), "queue overfilled")
    `BTPP_ASSERT_SAME(a_no_push_full, i_clk, i_rst_n, i_wr.push, !o_full, "push into a full queue")

endmodule

/* rtl/btpp_back.sv */
module btpp_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  btpp_pkg::t_q_rd i_head,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_stall,
    output btpp_pkg::t_out  o_data
);
    import btpp_pkg::*;
    `include "bracket_text_pretty_printer_unit_macros.svh"

    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_SECOND = 2'd1;
    localparam logic [1:0] PH_TABS   = 2'd2;
    localparam logic [1:0] PH_LAST   = 2'd3;

    logic [1:0]         r_phase, n_phase;
    logic [DEPTH_W-1:0] r_tab_left, n_tab_left;
    logic               r_out_valid, n_out_valid;
    t_out               r_out, n_out;
    logic               advance;
    logic [7:0]         v_char;
    logic               v_last;
    logic [1:0]         v_phase;
    logic [DEPTH_W-1:0] v_tab_left;

    assign advance = !r_out_valid || !i_stall;

    always_comb begin
        v_char     = i_head.cmd.ch;
        v_last     = 1'b0;
        v_phase    = r_phase;
        v_tab_left = r_tab_left;
        case (i_head.cmd.op)
            OP_PASS: begin
                v_last = 1'b1;
            end
            OP_COLON: begin
                case (r_phase)
                    PH_FIRST: begin
                        v_char  = CH_SPACE;
                        v_phase = PH_SECOND;
                    end
                    PH_SECOND: begin
                        v_char  = CH_COLON;
                        v_phase = PH_LAST;
                    end
                    default: begin
                        v_char = CH_SPACE;
                        v_last = 1'b1;
                    end
                endcase
            end
            OP_OPEN: begin
                case (r_phase)
                    PH_FIRST: begin
                        v_phase = PH_SECOND;
                    end
                    PH_SECOND: begin
                        v_char = CH_NL;
                        if (i_head.cmd.tabs == '0) begin
                            v_last = 1'b1;
                        end else begin
                            v_phase    = PH_TABS;
                            v_tab_left = i_head.cmd.tabs;
                        end
                    end
                    default: begin
                        v_char     = CH_TAB;
                        v_tab_left = r_tab_left - 1'b1;
                        v_last     = (r_tab_left == DEPTH_W'(1));
                    end
                endcase
            end
            default: begin
                case (r_phase)
                    PH_FIRST: begin
                        v_char = CH_NL;
                        if (i_head.cmd.tabs == '0) begin
                            v_phase = PH_LAST;
                        end else begin
                            v_phase    = PH_TABS;
                            v_tab_left = i_head.cmd.tabs;
                        end
                    end
                    PH_TABS: begin
                        v_char     = CH_TAB;
                        v_tab_left = r_tab_left - 1'b1;
                        if (r_tab_left == DEPTH_W'(1)) begin
                            v_phase = PH_LAST;
                        end
                    end
                    default: begin
                        v_last = 1'b1;
                    end
                endcase
            end
        endcase
        if (v_last) begin
            v_phase = PH_FIRST;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_tab_left  = r_tab_left;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        o_pop       = 1'b0;
        if (advance) begin
            n_out_valid = i_head.avail;
            if (i_head.avail) begin
                n_out.out_char    = v_char;
                n_out.last_of_run = v_last;
                n_phase           = v_phase;
                n_tab_left        = v_tab_left;
                o_pop             = v_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out      <= n_out;
        r_tab_left <= n_tab_left;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_FIRST;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    `BTPP_ASSERT_SAME(a_tabs_left, i_clk, i_rst_n, r_phase == PH_TABS, r_tab_left != '0, "tab run with no tabs left")
    `BTPP_ASSERT_NEXT(a_pop_loads, i_clk, i_rst_n, o_pop, r_out_valid && r_out.last_of_run, "pop without a final byte")

endmodule

/* rtl/bracket_text_pretty_printer_unit.sv */
// An accepted item is registered in the queue, and its first output byte is then registered by the output sequencer.
// A plain or quoted byte passes alone, a colon becomes space, colon, space, an open bracket
// or comma is followed by a newline and one tab per indent level; a close bracket comes after both.
// The output sequencer, emitting one byte per cycle unless i_stall holds it, sets the rate; a two-entry queue feeds it.
// Reset clears the nesting depth, the string and escape flags, the queue and the output valid flag.
module bracket_text_pretty_printer_unit #(
    parameter int MAX_DEPTH = btpp_pkg::MAX_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  btpp_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_stall,
    output btpp_pkg::t_out o_data
);
    import btpp_pkg::*;

    t_q_wr q_wr;
    t_q_rd q_rd;
    logic  q_full;
    logic  q_pop;

    btpp_front #(
        .MAX_DEPTH(MAX_DEPTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_data   (i_data),
        .i_q_full (q_full),
        .o_q_wr   (q_wr)
    );

    btpp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .o_full  (q_full),
        .o_rd    (q_rd),
        .i_pop   (q_pop)
    );

    btpp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (q_rd),
        .o_pop   (q_pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

endmodule
